@@ design/khm_pkg.sv @@
// Package for the k-way heap merge block: shared widths, defaults and register map.
// Depends on nothing; used by the result channel interface, the top level, the checker and the testbench.
`default_nettype none

package khm_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_LISTS  = 64;
   localparam int DEF_VALUE_BITS = 32;

   // fixed field widths
   localparam int SRC_W  = 6;   // source list number carried with each heap entry
   localparam int CFG_W  = 7;   // list_count register
   localparam int FILL_W = 7;   // fill-phase item counter

   // register map
   localparam int APB_ADDR_W = 3;
   localparam int APB_DATA_W = 32;
   localparam logic [APB_ADDR_W-3:0] REG_LIST_COUNT = '0;
   localparam logic [CFG_W-1:0] LIST_COUNT_RESET = CFG_W'(2);

endpackage

`default_nettype wire

@@ design/khm_req_if.sv @@
// Input channel of the k-way heap merge: one list head or end mark per item.
// Depends on nothing beyond its own parameter.
`default_nettype none

interface khm_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         list_end;

   modport source (output valid, output value, output list_end, input ready);
   modport sink   (input valid, input value, input list_end, output ready);
endinterface

`default_nettype wire

@@ design/khm_rsp_if.sv @@
// Result channel of the k-way heap merge: merged element, its source, or done.
// Depends on khm_pkg for the source width.
`default_nettype none

interface khm_rsp_if #(
   parameter int VALUE_BITS = 32
);
   import khm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value_res;
   logic [SRC_W-1:0]             source_list;
   logic                         done_res;

   modport source (output valid, output value_res, output source_list, output done_res,
                   input ready);
   modport sink   (input valid, input value_res, input source_list, input done_res,
                   output ready);
endinterface

`default_nettype wire

@@ design/k_way_heap_merge.sv @@
// Top level of the k-way heap merge: APB register, heap memory and sift-down sequencer.
// Depends on khm_pkg, khm_req_if and khm_rsp_if.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        value, list_end
//   rsp_chan  out        valid/ready        value_res, source_list, done_res
//   APB       in         psel/penable       paddr, pwdata -> prdata (pready tied high)
//
// Fill items other than the last give no result.
// A merge item sifts down from the root, one heap level at a time; the heap memory is
// read once per level and written once per level.
// The last fill item adds the bottom-up build: a sift-down from each inner node.
// Reset is synchronous; the heap memory is not cleared, only its size count.
// A waiting result does not block fill items; a new result waits for the output register.
`default_nettype none

module k_way_heap_merge #(
   parameter int MAX_LISTS  = khm_pkg::DEF_MAX_LISTS,
   parameter int VALUE_BITS = khm_pkg::DEF_VALUE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   khm_req_if.sink                            req_chan,
   khm_rsp_if.source                          rsp_chan,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [khm_pkg::APB_ADDR_W-1:0] paddr,
   input  wire logic [khm_pkg::APB_DATA_W-1:0] pwdata,
   output logic      [khm_pkg::APB_DATA_W-1:0] prdata,
   output logic                               pready
);
   import khm_pkg::*;

   localparam int AW     = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
   localparam int DEPTH  = 1 << AW;
   localparam int SIZE_W = $clog2(MAX_LISTS + 1);
   localparam int CW     = AW + 2;
   localparam int EW     = VALUE_BITS + SRC_W;
   localparam int CMPW   = (SIZE_W > FILL_W + 1) ? SIZE_W : FILL_W + 1;
   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_LISTS);
   localparam logic [CMPW-1:0]   MAX_CMP  = CMPW'(MAX_LISTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_LOAD,
      ST_LEVEL_RD,
      ST_LEVEL_DEC,
      ST_ROOT_RD,
      ST_EMIT
   } state_type;

   // control registers
   state_type          state_ff;
   logic [CFG_W-1:0]   list_count_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic               merging_ff;
   logic               build_ff;
   logic [SIZE_W-1:0]  bidx_ff;
   logic [AW-1:0]      pos_ff;
   logic [EW-1:0]      cur_ff;
   logic [SRC_W-1:0]   root_src_ff;
   logic               rsp_valid_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [SRC_W-1:0]   rsp_src_ff;
   logic               rsp_done_ff;

   // heap memory: one write port, two registered read ports
   logic [EW-1:0]      heap_mem_ff [DEPTH];
   logic [EW-1:0]      rd_a_ff;
   logic [EW-1:0]      rd_b_ff;
   logic [AW-1:0]      rd_addr_a;
   logic [AW-1:0]      rd_addr_b;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;

   // datapath
   logic               req_take;
   logic               csr_write;
   logic [SIZE_W-1:0]  base_size;
   logic               fill_store;
   logic [SIZE_W-1:0]  size_fill_in;
   logic [FILL_W:0]    fill_next;
   logic               fill_last;
   logic [CW-1:0]      l_idx;
   logic [CW-1:0]      r_idx;
   logic [CW-1:0]      size_ext;
   logic               l_ok;
   logic               r_ok;
   logic [VALUE_BITS-1:0] cur_key;
   logic [VALUE_BITS-1:0] l_key;
   logic [VALUE_BITS-1:0] r_key;
   logic [VALUE_BITS-1:0] best_key;
   logic               pick_l;
   logic               pick_r;
   logic               moves;
   logic [EW-1:0]      child_entry;
   logic [AW-1:0]      child_pos;
   logic               rsp_free;

   // APB register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite &&
                      (paddr[APB_ADDR_W-1:2] == REG_LIST_COUNT);
   always_comb begin
      prdata = '0;
      if (paddr[APB_ADDR_W-1:2] == REG_LIST_COUNT) begin
         prdata = APB_DATA_W'(list_count_ff);
      end
   end

   // channel signals
   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign req_take             = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.value_res   = rsp_value_ff;
   assign rsp_chan.source_list = rsp_src_ff;
   assign rsp_chan.done_res    = rsp_done_ff;
   assign rsp_free             = !rsp_valid_ff || rsp_chan.ready;

   // fill phase: append non-empty heads, detect the last fill item
   assign base_size    = (fill_ff == '0) ? '0 : size_ff;
   assign fill_store   = !req_chan.list_end && (base_size < MAX_SIZE);
   assign size_fill_in = base_size + SIZE_W'(fill_store);
   assign fill_next    = (FILL_W + 1)'(fill_ff) + (FILL_W + 1)'(1);
   assign fill_last    = (fill_next >= (FILL_W + 1)'(list_count_ff)) ||
                         (CMPW'(fill_next) >= MAX_CMP);

   // sift-down compare: strict less-than, left child first
   assign l_idx       = {1'b0, pos_ff, 1'b1};
   assign r_idx       = l_idx + CW'(1);
   assign size_ext    = CW'(size_ff);
   assign l_ok        = l_idx < size_ext;
   assign r_ok        = r_idx < size_ext;
   assign cur_key     = cur_ff[EW-1:SRC_W];
   assign l_key       = rd_a_ff[EW-1:SRC_W];
   assign r_key       = rd_b_ff[EW-1:SRC_W];
   assign pick_l      = l_ok && ($signed(l_key) < $signed(cur_key));
   assign best_key    = pick_l ? l_key : cur_key;
   assign pick_r      = r_ok && ($signed(r_key) < $signed(best_key));
   assign moves       = pick_l || pick_r;
   assign child_entry = pick_r ? rd_b_ff : rd_a_ff;
   assign child_pos   = pick_r ? r_idx[AW-1:0] : l_idx[AW-1:0];

   // memory address and write selection
   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = cur_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && !merging_ff) begin
               wr_en   = fill_store;
               wr_addr = base_size[AW-1:0];
               wr_data = {req_chan.value, fill_ff[SRC_W-1:0]};
            end else begin
               rd_addr_a = AW'(size_ff - SIZE_W'(1));
            end
         end
         ST_BUILD: begin
            rd_addr_a = AW'(bidx_ff - SIZE_W'(1));
         end
         ST_LEVEL_RD: begin
            rd_addr_a = l_idx[AW-1:0];
            rd_addr_b = r_idx[AW-1:0];
         end
         ST_LEVEL_DEC: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = moves ? child_entry : cur_ff;
         end
         ST_LOAD, ST_ROOT_RD, ST_EMIT: begin
            rd_addr_a = '0;
         end
         default: begin
            rd_addr_a = '0;
         end
      endcase
   end

   // heap memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem_ff[rd_addr_a];
      rd_b_ff <= heap_mem_ff[rd_addr_b];
   end

   // sequencer, register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         list_count_ff <= LIST_COUNT_RESET;
         size_ff       <= '0;
         fill_ff       <= '0;
         merging_ff    <= 1'b0;
         build_ff      <= 1'b0;
         bidx_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            list_count_ff <= pwdata[CFG_W-1:0];
         end
         // drop the result once taken; the emit state loads the next one itself
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  pos_ff <= '0;
                  if (!merging_ff) begin
                     size_ff <= size_fill_in;
                     if (fill_last) begin
                        fill_ff  <= '0;
                        bidx_ff  <= size_fill_in >> 1;
                        build_ff <= 1'b1;
                        state_ff <= ST_BUILD;
                     end else begin
                        fill_ff <= fill_next[FILL_W-1:0];
                     end
                  end else if (size_ff == '0) begin
                     state_ff <= ST_ROOT_RD;
                  end else if (req_chan.list_end) begin
                     // move the last entry to the root
                     size_ff  <= size_ff - SIZE_W'(1);
                     state_ff <= ST_LOAD;
                  end else begin
                     cur_ff   <= {req_chan.value, root_src_ff};
                     state_ff <= ST_LEVEL_RD;
                  end
               end
            end
            ST_BUILD: begin
               if (bidx_ff == '0) begin
                  build_ff <= 1'b0;
                  state_ff <= ST_ROOT_RD;
               end else begin
                  pos_ff   <= AW'(bidx_ff - SIZE_W'(1));
                  bidx_ff  <= bidx_ff - SIZE_W'(1);
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               cur_ff   <= rd_a_ff;
               state_ff <= ST_LEVEL_RD;
            end
            ST_LEVEL_RD: begin
               state_ff <= ST_LEVEL_DEC;
            end
            ST_LEVEL_DEC: begin
               if (moves) begin
                  pos_ff   <= child_pos;
                  state_ff <= ST_LEVEL_RD;
               end else if (build_ff) begin
                  state_ff <= ST_BUILD;
               end else begin
                  state_ff <= ST_ROOT_RD;
               end
            end
            ST_ROOT_RD: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               // hold until the output register is free
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (size_ff == '0) begin
                     rsp_value_ff <= '0;
                     rsp_src_ff   <= '0;
                     rsp_done_ff  <= 1'b1;
                     merging_ff   <= 1'b0;
                     fill_ff      <= '0;
                  end else begin
                     rsp_value_ff <= rd_a_ff[EW-1:SRC_W];
                     rsp_src_ff   <= rd_a_ff[SRC_W-1:0];
                     rsp_done_ff  <= 1'b0;
                     root_src_ff  <= rd_a_ff[SRC_W-1:0];
                     merging_ff   <= 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ tb/khm_merge_checker.sv @@
// Checker for the k-way heap merge: mirrors the heap, predicts every result item and
// compares it. Depends on khm_pkg, khm_req_if and khm_rsp_if; it only watches the ports.

module khm_merge_checker #(
   parameter int MAX_LISTS  = khm_pkg::DEF_MAX_LISTS,
   parameter int VALUE_BITS = khm_pkg::DEF_VALUE_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   khm_req_if                                  req_mon,
   khm_rsp_if                                  rsp_mon,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic                           pready,
   input  wire logic [khm_pkg::APB_ADDR_W-1:0] paddr,
   input  wire logic [khm_pkg::APB_DATA_W-1:0] pwdata,
   input  wire logic [khm_pkg::APB_DATA_W-1:0] prdata,
   output int                                  results_due,
   output int                                  fail_count
);
   import khm_pkg::*;

   typedef logic signed [VALUE_BITS-1:0] key_type;

   typedef struct packed {
      key_type          value;
      logic [SRC_W-1:0] source;
      logic             done;
   } merged_type;

   // mirror of the block's heap and phase state
   key_type          heap_key [MAX_LISTS];
   logic [SRC_W-1:0] heap_src [MAX_LISTS];
   int               heap_count;
   int               fill_pos;
   bit               merging;
   logic [CFG_W-1:0] list_count;

   // merged outputs still owed by the block, oldest first
   merged_type merged_due [$];

   // push an entry down until no child is strictly smaller
   function automatic void sift_from(input int start);
      int               node;
      int               least;
      int               lc;
      bit               settled;
      key_type          tk;
      logic [SRC_W-1:0] ts;
      node    = start;
      settled = 1'b0;
      while (!settled && node < heap_count) begin
         least = node;
         lc    = 2 * node + 1;
         if (lc < heap_count && heap_key[lc] < heap_key[least]) least = lc;
         if (lc + 1 < heap_count && heap_key[lc + 1] < heap_key[least]) least = lc + 1;
         if (least == node) begin
            settled = 1'b1;
         end else begin
            tk              = heap_key[node];
            heap_key[node]  = heap_key[least];
            heap_key[least] = tk;
            ts              = heap_src[node];
            heap_src[node]  = heap_src[least];
            heap_src[least] = ts;
            node            = least;
         end
      end
   endfunction

   // advance the mirror by one input item and queue the result it causes, if any
   function automatic void absorb_item(input key_type v, input logic last_mark);
      int         lists;
      int         node;
      bit         emits;
      merged_type head;
      emits = 1'b1;
      if (!merging) begin
         if (list_count == '0) lists = 1;
         else if (int'(list_count) > MAX_LISTS) lists = MAX_LISTS;
         else lists = int'(list_count);
         if (fill_pos == 0) heap_count = 0;
         if (!last_mark && heap_count < MAX_LISTS) begin
            heap_key[heap_count] = v;
            heap_src[heap_count] = SRC_W'(fill_pos);
            heap_count++;
         end
         fill_pos++;
         if (fill_pos < lists) begin
            emits = 1'b0;
         end else begin
            // build bottom-up once the last head is in
            for (node = heap_count / 2; node > 0; node--) sift_from(node - 1);
            fill_pos = 0;
         end
      end else if (heap_count != 0) begin
         if (last_mark) begin
            heap_count--;
            heap_key[0] = heap_key[heap_count];
            heap_src[0] = heap_src[heap_count];
         end else begin
            heap_key[0] = v;
         end
         sift_from(0);
      end
      if (emits) begin
         if (heap_count == 0) begin
            head.value  = '0;
            head.source = '0;
            head.done   = 1'b1;
            merging     = 1'b0;
            fill_pos    = 0;
         end else begin
            head.value  = heap_key[0];
            head.source = heap_src[0];
            head.done   = 1'b0;
            merging     = 1'b1;
         end
         merged_due.push_back(head);
      end
   endfunction

   // compare results first, then track the register, then predict from the new item
   always @(posedge clock) begin : watch
      merged_type head;
      if (reset) begin
         heap_count = 0;
         fill_pos   = 0;
         merging    = 1'b0;
         list_count = LIST_COUNT_RESET;
         fail_count = 0;
         merged_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (merged_due.size() == 0) begin
               $error("result item with none expected: value_res %0d source_list %0d done_res %0b",
                      rsp_mon.value_res, rsp_mon.source_list, rsp_mon.done_res);
               fail_count++;
            end else begin
               head = merged_due.pop_front();
               if (rsp_mon.value_res !== head.value) begin
                  $error("value_res: expected %0d, got %0d", head.value, rsp_mon.value_res);
                  fail_count++;
               end
               if (rsp_mon.source_list !== head.source) begin
                  $error("source_list: expected %0d, got %0d", head.source, rsp_mon.source_list);
                  fail_count++;
               end
               if (rsp_mon.done_res !== head.done) begin
                  $error("done_res: expected %0b, got %0b", head.done, rsp_mon.done_res);
                  fail_count++;
               end
            end
         end
         if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_LIST_COUNT) begin
            if (pwrite) begin
               list_count = pwdata[CFG_W-1:0];
            end else if (prdata !== APB_DATA_W'(list_count)) begin
               $error("list_count read: expected %0d, got %0d", list_count, prdata);
               fail_count++;
            end
         end
         if (req_mon.valid && req_mon.ready) absorb_item(req_mon.value, req_mon.list_end);
      end
      results_due <= merged_due.size();
   end

endmodule

@@ tb/tb_k_way_heap_merge.sv @@
// Testbench top for the k-way heap merge: clock, reset, item and register stimulus, verdict.
// Depends on khm_pkg, the two channel interfaces, k_way_heap_merge and khm_merge_checker.

module tb_k_way_heap_merge;
   import khm_pkg::*;

   localparam int MAX_LISTS       = DEF_MAX_LISTS;
   localparam int VALUE_BITS      = DEF_VALUE_BITS;
   localparam int IDLE_LIMIT      = 5000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int FINAL_CYCLES    = 64;
   localparam int ITEMS_PER_PHASE = 350;
   localparam logic [APB_ADDR_W-1:0] LIST_COUNT_ADDR = {REG_LIST_COUNT, 2'b00};

   typedef logic signed [VALUE_BITS-1:0] key_type;

   localparam key_type KEY_MIN = {1'b1, {(VALUE_BITS - 1){1'b0}}};
   localparam key_type KEY_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [APB_ADDR_W-1:0] paddr;
   logic [APB_DATA_W-1:0] pwdata;
   logic [APB_DATA_W-1:0] prdata;
   logic                  pready;

   int results_due;
   int fail_count;
   int send_gap;
   int recv_stall;
   int items_sent;
   int live_heads;
   int cur_lists;
   int idle_cycles;

   khm_req_if #(.VALUE_BITS(VALUE_BITS)) req_chan ();
   khm_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_chan ();

   k_way_heap_merge #(
      .MAX_LISTS (MAX_LISTS),
      .VALUE_BITS(VALUE_BITS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   khm_merge_checker #(
      .MAX_LISTS (MAX_LISTS),
      .VALUE_BITS(VALUE_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .results_due(results_due),
      .fail_count (fail_count)
   );

   always #10 clock = ~clock;

   // stall the result channel at the phase's rate
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
   end

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // small values for ties, full-range values as often, and now and then the extremes
   function automatic key_type pick_value();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) return key_type'($urandom);
      if (pick < 80) return key_type'($urandom_range(6)) - key_type'(3);
      case ($urandom_range(4))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return '1;
         3: return '0;
         default: return key_type'(1);
      endcase
   endfunction

   // offer one item, idling first at the phase's rate, and hold until it is accepted
   task automatic send_item(input key_type v, input logic last_mark);
      if ($urandom_range(99) < send_gap) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.value    <= v;
      req_chan.list_end <= last_mark;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // hold the sender until every result item is back and the block has gone quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CFG_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= LIST_COUNT_ADDR;
      pwdata  <= APB_DATA_W'(data);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // write list_count while idle and read it back
   task automatic set_list_count(input logic [CFG_W-1:0] cfg);
      settle();
      csr_access(1'b1, cfg);
      csr_access(1'b0, '0);
      if (cfg == '0) cur_lists = 1;
      else if (int'(cfg) > MAX_LISTS) cur_lists = MAX_LISTS;
      else cur_lists = int'(cfg);
   endtask

   task automatic fill_heads(input int n, input int empty_pct);
      logic empty;
      repeat (n) begin
         empty = ($urandom_range(99) < empty_pct);
         if (!empty) live_heads++;
         send_item(pick_value(), empty);
      end
   endtask

   // refill the named list until every list has run out
   task automatic drain_heads(input int end_pct);
      logic gone;
      while (live_heads > 0) begin
         gone = ($urandom_range(99) < end_pct);
         if (gone) live_heads--;
         send_item(pick_value(), gone);
      end
   endtask

   // one complete merge, sometimes with a new list count or a fill cut short
   task automatic random_round();
      int               pick;
      int               cut;
      logic [CFG_W-1:0] cfg;
      if ($urandom_range(99) < 40) begin
         pick = $urandom_range(99);
         if (pick < 50) cfg = CFG_W'($urandom_range(1, 6));
         else if (pick < 72) cfg = CFG_W'($urandom_range(7, 16));
         else if (pick < 84) cfg = CFG_W'($urandom_range(17, 63));
         else if (pick < 90) cfg = CFG_W'(MAX_LISTS);
         else if (pick < 94) cfg = '0;
         else if (pick < 97) cfg = CFG_W'($urandom_range(MAX_LISTS + 1, 127));
         else cfg = CFG_W'(1);
         set_list_count(cfg);
      end
      live_heads = 0;
      if (cur_lists >= 3 && $urandom_range(9) == 0) begin
         // lower the count to at most the fill position so the next head closes the fill
         cut = $urandom_range(1, cur_lists - 1);
         fill_heads(cut, 20);
         set_list_count(CFG_W'($urandom_range(0, cut)));
         fill_heads(1, 20);
      end else begin
         fill_heads(cur_lists, ($urandom_range(2) == 0) ? 60 : 15);
      end
      drain_heads($urandom_range(20, 70));
   endtask

   initial begin : stimulus
      int phase;
      int phase_end;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.value    = '0;
      req_chan.list_end = 1'b0;
      rsp_chan.ready    = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      send_gap          = 0;
      recv_stall        = 0;
      items_sent        = 0;
      live_heads        = 0;
      cur_lists         = int'(LIST_COUNT_RESET);
      idle_cycles       = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset list count of two, extreme heads, a refill with the minimum, then both ends
      send_item(KEY_MAX, 1'b0);
      send_item(KEY_MIN, 1'b0);
      send_item(KEY_MIN, 1'b0);
      send_item(pick_value(), 1'b1);
      send_item(pick_value(), 1'b1);

      // every list empty: a lone done item
      set_list_count(CFG_W'(3));
      repeat (3) send_item(pick_value(), 1'b1);

      // a zero count behaves as one list
      set_list_count('0);
      send_item('0, 1'b0);
      send_item(pick_value(), 1'b1);

      // equal keys must not displace the entry above them
      set_list_count(CFG_W'(4));
      repeat (5) send_item(key_type'(5), 1'b0);
      repeat (4) send_item(pick_value(), 1'b1);

      // lower the count mid-fill so the next head ends the fill
      set_list_count(CFG_W'(6));
      live_heads = 0;
      fill_heads(3, 0);
      set_list_count(CFG_W'(2));
      fill_heads(1, 0);
      drain_heads(100);

      // random merges under each idling pattern
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_gap = 0;
               recv_stall <= 0;
            end
            1: begin
               send_gap = 55;
               recv_stall <= 0;
            end
            2: begin
               send_gap = 0;
               recv_stall <= 55;
            end
            default: begin
               send_gap = 33;
               recv_stall <= 33;
            end
         endcase
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) random_round();
      end

      settle();
      repeat (FINAL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/khm_pkg.sv
design/khm_req_if.sv
design/khm_rsp_if.sv
design/k_way_heap_merge.sv
tb/khm_merge_checker.sv
tb/tb_k_way_heap_merge.sv
